// ----- sv/prvg_pkg.sv -----
// Shared types and constants of the polyline ribbon vertex generator.
`default_nettype none
package prvg_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned DiffW  = 25;
    localparam int unsigned WidthW = 16;
    localparam int unsigned PairW  = 16;
    localparam int unsigned OffW   = 17;
    localparam int unsigned QDepth = 2;

    typedef struct packed {
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [DiffW-1:0]  dx;
        logic signed [DiffW-1:0]  dy;
        logic                     fin;
        logic                     single;
        logic                     degen;
    } cmd_t;

    typedef struct packed {
        logic                          full;
        logic                          empty;
        logic [$clog2(QDepth+1)-1:0]   count;
    } qstat_t;

    function automatic logic signed [CoordW-1:0] sat_add(
        input logic signed [CoordW-1:0] p,
        input logic signed [OffW-1:0]   o
    );
        logic signed [CoordW:0] s;
        s = {p[CoordW-1], p} + (CoordW+1)'(o);
        if (s[CoordW] != s[CoordW-1]) begin
            sat_add = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end else begin
            sat_add = s[CoordW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/prvg_queue.sv -----
// Short request queue between the front and the back part.
`default_nettype none
module prvg_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire prvg_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output prvg_pkg::cmd_t     head_cmd,
    output prvg_pkg::qstat_t   stat
);
    localparam int unsigned PtrW = $clog2(prvg_pkg::QDepth);
    localparam int unsigned CntW = $clog2(prvg_pkg::QDepth + 1);

    prvg_pkg::cmd_t mem_reg [prvg_pkg::QDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == CntW'(prvg_pkg::QDepth));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(prvg_pkg::QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(prvg_pkg::QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CntW'(push) - CntW'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- sv/prvg_front.sv -----
// Front part: accepts points, tracks the previous point and classifies each request.
`default_nettype none
module prvg_front (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    input  wire logic signed [prvg_pkg::CoordW-1:0]    in_x,
    input  wire logic signed [prvg_pkg::CoordW-1:0]    in_y,
    input  wire logic                                  in_fin,
    input  wire logic                                  q_full,
    output logic                                       in_ready,
    output logic                                       push,
    output prvg_pkg::cmd_t                             push_cmd
);
    logic signed [prvg_pkg::CoordW-1:0] prior_x_reg;
    logic signed [prvg_pkg::CoordW-1:0] prior_y_reg;
    logic                               have_prior_reg;
    logic                               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (have_prior_reg || in_fin);

    always_comb begin
        push_cmd.px     = prior_x_reg;
        push_cmd.py     = prior_y_reg;
        push_cmd.x      = in_x;
        push_cmd.y      = in_y;
        push_cmd.dx     = {in_x[prvg_pkg::CoordW-1], in_x} - {prior_x_reg[prvg_pkg::CoordW-1], prior_x_reg};
        push_cmd.dy     = {in_y[prvg_pkg::CoordW-1], in_y} - {prior_y_reg[prvg_pkg::CoordW-1], prior_y_reg};
        push_cmd.fin    = in_fin;
        push_cmd.single = !have_prior_reg;
        push_cmd.degen  = !have_prior_reg || (push_cmd.dx == '0 && push_cmd.dy == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_x_reg    <= '0;
            prior_y_reg    <= '0;
            have_prior_reg <= 1'b0;
        end else if (accept) begin
            if (in_fin) begin
                prior_x_reg    <= '0;
                prior_y_reg    <= '0;
                have_prior_reg <= 1'b0;
            end else begin
                prior_x_reg    <= in_x;
                prior_y_reg    <= in_y;
                have_prior_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/prvg_back.sv -----
// Back part: normalizes each non-degenerate segment with an iterative root and divider and emits vertex pairs.
`default_nettype none
module prvg_back #(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [prvg_pkg::WidthW-1:0]           ribbon_width,
    input  wire prvg_pkg::cmd_t                        head_cmd,
    input  wire logic                                  q_empty,
    output logic                                       pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [prvg_pkg::CoordW-1:0]         left_x,
    output logic signed [prvg_pkg::CoordW-1:0]         left_y,
    output logic signed [prvg_pkg::CoordW-1:0]         right_x,
    output logic signed [prvg_pkg::CoordW-1:0]         right_y,
    output logic [prvg_pkg::PairW-1:0]                 pair_number,
    output logic                                       last_pair,
    output logic                                       degenerate
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQUARE, S_SUM, S_ROOT, S_MULT, S_LOAD, S_DIV, S_EMIT_A, S_EMIT_B
    } state_t;

    state_t                state_reg;
    prvg_pkg::cmd_t        cmd_reg;
    logic [4:0]            cnt_reg;
    logic [49:0]           sqx_reg, sqy_reg;
    logic [63:0]           v_reg;
    logic [33:0]           rem_reg;
    logic [31:0]           root_reg;
    logic [39:0]           prodx_reg, prody_reg;
    logic [47:0]           remx_reg, remy_reg, den_reg;
    logic [15:0]           qx_reg, qy_reg;
    logic signed [prvg_pkg::OffW-1:0] ox_reg, oy_reg;
    logic [prvg_pkg::PairW-1:0]       pc_reg;

    logic [34:0]           rem_sh;
    logic [34:0]           trial;
    logic [24:0]           mag_dx, mag_dy;
    logic [16:0]           pc_inc;
    logic [prvg_pkg::PairW-1:0] pc_wrap;
    logic                  out_free;
    logic                  emit_now;

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign rem_sh   = {rem_reg[32:0], v_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign mag_dx   = cmd_reg.dx[24] ? 25'(-cmd_reg.dx) : 25'(cmd_reg.dx);
    assign mag_dy   = cmd_reg.dy[24] ? 25'(-cmd_reg.dy) : 25'(cmd_reg.dy);
    assign pc_inc   = {1'b0, pc_reg} + 17'd1;
    assign pc_wrap  = (pc_inc >= 17'(MAX_POINTS)) ? '0 : pc_inc[15:0];
    assign out_free = !out_valid || out_ready;
    assign emit_now = out_free && (((state_reg == S_EMIT_A) && (cnt_reg != 5'd16))
                                   || (state_reg == S_EMIT_B));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            if (out_valid && out_ready && !emit_now) begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg <= head_cmd;
                        if (head_cmd.degen) begin
                            ox_reg    <= '0;
                            oy_reg    <= '0;
                            state_reg <= S_EMIT_A;
                        end else begin
                            state_reg <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE: begin
                    sqx_reg   <= 50'(cmd_reg.dx * cmd_reg.dx);
                    sqy_reg   <= 50'(cmd_reg.dy * cmd_reg.dy);
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    v_reg     <= {sqx_reg + sqy_reg, 14'b0};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    v_reg <= {v_reg[61:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg  <= 34'(rem_sh - trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_MULT;
                    end
                end
                S_MULT: begin
                    prodx_reg <= mag_dy[23:0] * ribbon_width;
                    prody_reg <= mag_dx[23:0] * ribbon_width;
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    remx_reg  <= {1'b0, prodx_reg, 7'b0} + {16'b0, root_reg};
                    remy_reg  <= {1'b0, prody_reg, 7'b0} + {16'b0, root_reg};
                    den_reg   <= {root_reg, 1'b0, 15'b0};
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (remx_reg >= den_reg) begin
                        remx_reg <= remx_reg - den_reg;
                        qx_reg   <= {qx_reg[14:0], 1'b1};
                    end else begin
                        qx_reg   <= {qx_reg[14:0], 1'b0};
                    end
                    if (remy_reg >= den_reg) begin
                        remy_reg <= remy_reg - den_reg;
                        qy_reg   <= {qy_reg[14:0], 1'b1};
                    end else begin
                        qy_reg   <= {qy_reg[14:0], 1'b0};
                    end
                    den_reg <= {1'b0, den_reg[47:1]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        state_reg <= S_EMIT_A;
                    end
                end
                S_EMIT_A: begin
                    if (cnt_reg == 5'd16) begin
                        ox_reg  <= cmd_reg.dy[24] ? $signed({1'b0, qx_reg})
                                                  : -$signed({1'b0, qx_reg});
                        oy_reg  <= cmd_reg.dx[24] ? -$signed({1'b0, qy_reg})
                                                  : $signed({1'b0, qy_reg});
                        cnt_reg <= '0;
                    end else if (out_free) begin
                        out_valid   <= 1'b1;
                        pair_number <= pc_reg;
                        degenerate  <= cmd_reg.degen;
                        if (cmd_reg.single) begin
                            left_x    <= cmd_reg.x;
                            left_y    <= cmd_reg.y;
                            right_x   <= cmd_reg.x;
                            right_y   <= cmd_reg.y;
                            last_pair <= 1'b1;
                            pc_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            left_x    <= prvg_pkg::sat_add(cmd_reg.px, ox_reg);
                            left_y    <= prvg_pkg::sat_add(cmd_reg.py, oy_reg);
                            right_x   <= prvg_pkg::sat_add(cmd_reg.px, -ox_reg);
                            right_y   <= prvg_pkg::sat_add(cmd_reg.py, -oy_reg);
                            last_pair <= 1'b0;
                            pc_reg    <= pc_wrap;
                            state_reg <= cmd_reg.fin ? S_EMIT_B : S_IDLE;
                        end
                    end
                end
                S_EMIT_B: begin
                    if (out_free) begin
                        out_valid   <= 1'b1;
                        pair_number <= pc_reg;
                        degenerate  <= cmd_reg.degen;
                        left_x      <= prvg_pkg::sat_add(cmd_reg.x, ox_reg);
                        left_y      <= prvg_pkg::sat_add(cmd_reg.y, oy_reg);
                        right_x     <= prvg_pkg::sat_add(cmd_reg.x, -ox_reg);
                        right_y     <= prvg_pkg::sat_add(cmd_reg.y, -oy_reg);
                        last_pair   <= 1'b1;
                        pc_reg      <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/polyline_ribbon_vertex_generator.sv -----
// Top level of the polyline ribbon vertex generator.
`default_nettype none
// Centerline points enter on the s_ stream and leave as left/right vertex pairs on the m_ stream.
// The first point of a line gives no pair unless it ends the line; each later point gives the
// pair of the point before it, and the final point adds its own pair. A segment request holds
// the back part from the cycle it leaves the queue until its pair is registered, and until the
// final pair when it carries one: two squares, a 32-step bitwise square root, a multiply and a
// 16-step divider pair for both offset components. Single-point lines and zero-length segments
// skip this arithmetic. A stalled output holds the back part further. A two-request queue lets
// the input run ahead of the arithmetic.
module polyline_ribbon_vertex_generator #(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,   // point_x, point_y
    input  wire logic          s_tlast,   // final_point
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [111:0]       m_tdata,   // left_x, left_y, right_x, right_y, pair_number
    output logic               m_tlast,   // last_pair
    output logic               m_tuser    // degenerate
);
    logic [prvg_pkg::WidthW-1:0] width_reg;
    logic                        push, pop;
    prvg_pkg::cmd_t              push_cmd, head_cmd;
    prvg_pkg::qstat_t            qstat;
    logic signed [23:0]          lx, ly, rx, ry;
    logic [15:0]                 pn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 16'd256;
        end else if (cfg_we) begin
            width_reg <= cfg_wdata;
        end
    end

    prvg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_x     (s_tdata[23:0]),
        .in_y     (s_tdata[47:24]),
        .in_fin   (s_tlast),
        .q_full   (qstat.full),
        .in_ready (s_tready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    prvg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (qstat)
    );

    prvg_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ribbon_width (width_reg),
        .head_cmd     (head_cmd),
        .q_empty      (qstat.empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .left_x       (lx),
        .left_y       (ly),
        .right_x      (rx),
        .right_y      (ry),
        .pair_number  (pn),
        .last_pair    (m_tlast),
        .degenerate   (m_tuser)
    );

    assign m_tdata = {pn, ry, rx, ly, lx};

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= 2'(prvg_pkg::QDepth))
        else $error("request queue overflow");
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == !qstat.full)
        else $error("input ready disagrees with queue level");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("request taken from empty queue");
endmodule
`default_nettype wire

// ----- tb/sv/polyline_ribbon_vertex_generator_checker.sv -----
// Checker that predicts the vertex pairs of the ribbon generator and compares them.
module polyline_ribbon_vertex_generator_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [47:0]  s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         m_tuser,
    output int                errors,
    output int                pending,
    output int                pairs_seen,
    output int                degenerate_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [prvg_pkg::CoordW-1:0] lx;
        logic signed [prvg_pkg::CoordW-1:0] ly;
        logic signed [prvg_pkg::CoordW-1:0] rx;
        logic signed [prvg_pkg::CoordW-1:0] ry;
        logic [prvg_pkg::PairW-1:0]         pair_no;
        logic                               last;
        logic                               degen;
    } vertex_pair_t;

    vertex_pair_t expected_pairs[$];

    logic [prvg_pkg::WidthW-1:0]        width_reg;
    logic signed [prvg_pkg::CoordW-1:0] prev_x;
    logic signed [prvg_pkg::CoordW-1:0] prev_y;
    logic                               prev_valid;
    logic [prvg_pkg::PairW-1:0]         next_pair;

    assign pending = expected_pairs.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint offset_of(longint c, longint unsigned len);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned q;
        mag = (c < 0) ? -c : c;
        num = mag * width_reg * 64;
        q = (2 * num + len) / (2 * len);
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [prvg_pkg::CoordW-1:0] clamp_coord(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[prvg_pkg::CoordW-1:0];
    endfunction

    task automatic add_pair(longint px, longint py, longint ox, longint oy, logic last,
                            logic degen);
        vertex_pair_t p;
        p.lx = clamp_coord(px + ox);
        p.ly = clamp_coord(py + oy);
        p.rx = clamp_coord(px - ox);
        p.ry = clamp_coord(py - oy);
        p.pair_no = next_pair;
        p.last = last;
        p.degen = degen;
        expected_pairs.insert(expected_pairs.size(), p);
        next_pair = next_pair + 1'b1;
    endtask

    task automatic predict_point(logic signed [prvg_pkg::CoordW-1:0] x,
                                 logic signed [prvg_pkg::CoordW-1:0] y, logic fin);
        longint dx;
        longint dy;
        longint unsigned s;
        longint unsigned len;
        longint ox;
        longint oy;
        logic degen;
        if (!prev_valid) begin
            if (fin) begin
                add_pair(x, y, 0, 0, 1'b1, 1'b1);
                next_pair = '0;
            end else begin
                prev_x = x;
                prev_y = y;
                prev_valid = 1'b1;
            end
            return;
        end
        dx = longint'(x) - longint'(prev_x);
        dy = longint'(y) - longint'(prev_y);
        s = dx * dx + dy * dy;
        degen = (s == 0);
        ox = 0;
        oy = 0;
        if (!degen) begin
            len = int_sqrt(s << 14);
            ox = offset_of(-dy, len);
            oy = offset_of(dx, len);
        end
        add_pair(prev_x, prev_y, ox, oy, 1'b0, degen);
        if (fin) begin
            add_pair(x, y, ox, oy, 1'b1, degen);
            prev_valid = 1'b0;
            next_pair = '0;
            prev_x = '0;
            prev_y = '0;
        end else begin
            prev_x = x;
            prev_y = y;
        end
    endtask

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, field, want, got);
        errors++;
    endtask

    task automatic check_pair();
        vertex_pair_t e;
        if (expected_pairs.size() == 0) begin
            $display("%0t: vertex pair arrived with none expected", $realtime);
            errors++;
            return;
        end
        e = expected_pairs.pop_front();
        pairs_seen++;
        if (m_tuser) degenerate_seen++;
        if (m_tdata[23:0] !== e.lx) report_mismatch("left_x", e.lx, m_tdata[23:0]);
        if (m_tdata[47:24] !== e.ly) report_mismatch("left_y", e.ly, m_tdata[47:24]);
        if (m_tdata[71:48] !== e.rx) report_mismatch("right_x", e.rx, m_tdata[71:48]);
        if (m_tdata[95:72] !== e.ry) report_mismatch("right_y", e.ry, m_tdata[95:72]);
        if (m_tdata[111:96] !== e.pair_no) report_mismatch("pair_number", e.pair_no,
                                                           m_tdata[111:96]);
        if (m_tlast !== e.last) report_mismatch("last_pair", e.last, m_tlast);
        if (m_tuser !== e.degen) report_mismatch("degenerate", e.degen, m_tuser);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 16'd256;
            prev_x = '0;
            prev_y = '0;
            prev_valid = 1'b0;
            next_pair = '0;
            errors = 0;
            pairs_seen = 0;
            degenerate_seen = 0;
            expected_pairs.delete();
        end else begin
            if (cfg_we) width_reg <= cfg_wdata;
            if (s_tvalid && s_tready) predict_point(s_tdata[23:0], s_tdata[47:24], s_tlast);
            if (m_tvalid && m_tready) check_pair();
        end
    end

endmodule

// ----- tb/sv/polyline_ribbon_vertex_generator_test.sv -----
// Testbench top that drives point streams into the ribbon generator and gives the verdict.
module polyline_ribbon_vertex_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    int           errors;
    int           pending;
    int           pairs_seen;
    int           degenerate_seen;
    int           points_sent;
    logic         gaps_on;
    logic         hold_req;
    logic         hold_done;

    localparam logic [23:0] XMAX = 24'h7FFFFF;
    localparam logic [23:0] XMIN = 24'h800000;

    polyline_ribbon_vertex_generator u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    polyline_ribbon_vertex_generator_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .errors(errors), .pending(pending), .pairs_seen(pairs_seen),
        .degenerate_seen(degenerate_seen)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d vertex pairs still expected.", pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic send_point(logic [23:0] x, logic [23:0] y, logic fin);
        s_tdata <= {y, x};
        s_tlast <= fin;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic set_width(logic [15:0] w);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_line();
        int n;
        int mode;
        logic [23:0] x;
        logic [23:0] y;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
        mode = $urandom_range(0, 3);
        x = 24'($urandom());
        y = 24'($urandom());
        for (int i = 0; i < n; i++) begin
            send_point(x, y, i == n - 1);
            case (mode)
                0: begin
                    x = x + 24'($signed($urandom_range(0, 2048)) - 1024);
                    y = y + 24'($signed($urandom_range(0, 2048)) - 1024);
                end
                1: begin
                    x = 24'($urandom());
                    y = 24'($urandom());
                end
                2: begin
                    if ($urandom_range(0, 1)) begin
                        x = x + 24'($signed($urandom_range(0, 64)) - 32);
                        y = y + 24'($signed($urandom_range(0, 64)) - 32);
                    end
                end
                default: begin
                    x = x + 24'($urandom_range(0, 3) * 256);
                    y = y + 24'($urandom_range(0, 3) * 256);
                end
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        points_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_point(24'd100, 24'd200, 1'b1);
        send_point(24'd0, 24'd0, 1'b0);
        send_point(24'd256, 24'd0, 1'b0);
        send_point(24'd256, 24'd256, 1'b1);
        send_point(24'd5, 24'd5, 1'b0);
        send_point(24'd5, 24'd5, 1'b1);
        send_point(XMAX, XMAX, 1'b0);
        send_point(XMIN, XMIN, 1'b1);
        send_point(XMIN, 24'd0, 1'b0);
        send_point(XMIN, 24'd0, 1'b0);
        send_point(XMAX, 24'd0, 1'b1);
        set_width(16'hFFFF);
        send_point(XMAX - 24'd10, 24'd0, 1'b0);
        send_point(XMAX - 24'd10, 24'd256, 1'b0);
        send_point(XMIN + 24'd10, XMAX, 1'b1);
        send_point(XMIN, XMIN, 1'b1);
        send_point(24'd0, XMIN, 1'b0);
        send_point(24'd1, XMAX, 1'b1);
        set_width(16'd0);
        send_point(24'd300, 24'd300, 1'b0);
        send_point(24'd900, 24'd100, 1'b1);

        set_width(16'($urandom()));
        hold_req = 1'b1;
        while (points_sent < 160) send_random_line();
        set_width(16'hFFFF);
        while (points_sent < 290) send_random_line();
        set_width(16'($urandom()));
        while (points_sent < 420) send_random_line();
        set_width(16'd256);
        gaps_on = 1'b0;
        while (points_sent < 520) send_random_line();
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d points in lines of one to eight, under five ribbon widths.",
                 points_sent);
        $display("Checked %0d vertex pairs, %0d of them degenerate.", pairs_seen,
                 degenerate_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
